>>> rtl/swr_pkg.sv
// Shared types, constants and state encoding for the two-channel window reject block.
// No dependencies; every other rtl file except swr_ram imports this package.
`default_nettype none

package swr_pkg;

   // Defaults for the top-level parameters
   localparam int WINDOW_DEF    = 49;
   localparam int CODE_BITS_DEF = 24;

   // Fixed field widths at the ports
   localparam int IN_CODE_W  = 24;
   localparam int OUT_CODE_W = 24;
   localparam int CHAN_W     = 2;
   localparam int CUT_W      = 24;
   localparam int SIGMA_W    = 8;
   localparam int SIGMA_SQ_W = 2 * SIGMA_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   // Multiplier digit width (bits of the second operand per step)
   localparam int MUL_DIGIT = 8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_CUTOFF = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIGMA  = 2'd1;

   // Register reset values
   localparam logic [CUT_W-1:0]   CUTOFF_RST = 24'd335544;
   localparam logic [SIGMA_W-1:0] SIGMA_RST  = 8'd16;

   // Channel tags that are stored
   localparam logic [CHAN_W-1:0] CHAN_X = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_Z = 2'd1;

   typedef struct packed {
      logic [IN_CODE_W-1:0] sample_code;
      logic [CHAN_W-1:0]    chan;
   } req_type;

   typedef struct packed {
      logic [OUT_CODE_W-1:0] x_code;
      logic                  x_valid;
      logic [OUT_CODE_W-1:0] z_code;
      logic                  z_valid;
   } rsp_type;

   // One queued beat, already classified
   typedef struct packed {
      logic [IN_CODE_W-1:0] code;
      logic                 chan1;
      logic                 keep;
   } q_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DATA,
      ST_MWAIT,
      ST_NQ,
      ST_SQ,
      ST_LIM,
      ST_RESULT
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/swr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 49
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/swr_mul.sv
// Sequential unsigned multiplier, one 8-bit digit of the second operand per cycle.
// Depends on swr_pkg (MUL_DIGIT). Product is truncated to ACC_W bits.
`default_nettype none

module swr_mul
   import swr_pkg::*;
#(
   parameter int ACC_W = 96,
   parameter int B_W   = 41
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ACC_W-1:0] a,
   input  wire logic [B_W-1:0]   b,
   output logic                  done,
   output logic      [ACC_W-1:0] prod
);

   logic                       busy_ff;
   logic [ACC_W-1:0]           a_ff;
   logic [B_W-1:0]             b_ff;
   logic [ACC_W-1:0]           acc_ff;
   logic [ACC_W+MUL_DIGIT-1:0] pp;

   // one partial product per cycle
   assign pp   = a_ff * b_ff[MUL_DIGIT-1:0];
   assign done = busy_ff && (b_ff == '0);
   assign prod = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff && (b_ff != '0)) begin
         acc_ff <= acc_ff + pp[ACC_W-1:0];
         a_ff   <= a_ff << MUL_DIGIT;
         b_ff   <= b_ff >> MUL_DIGIT;
      end
   end

endmodule

`default_nettype wire

>>> rtl/swr_front.sv
// Front end: accepts request beats, tags stored channels, queues them for the back end.
// Depends on swr_pkg (req_type, q_item_type, QUEUE_DEPTH).
`default_nettype none

module swr_front
   import swr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            q_valid,
   output q_item_type      q_item,
   input  wire logic       q_pop
);

   localparam int QP_W = $clog2(QUEUE_DEPTH);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   q_item_type      q_ff [QUEUE_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff;
   logic [QP_W-1:0] rd_ptr_ff;
   logic [QC_W-1:0] cnt_ff;
   logic            push;
   logic            pop;
   q_item_type      item_in;

   // classify: only channels 0 and 1 are stored
   always_comb begin
      item_in.code  = req_data.sample_code;
      item_in.chan1 = req_data.chan[0];
      item_in.keep  = req_data.chan inside {CHAN_X, CHAN_Z};
   end

   assign req_ready = (cnt_ff != QC_W'(QUEUE_DEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   // queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QP_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QP_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/swr_back.sv
// Back end: window update, two passes over the first differences, held-code update.
// Depends on swr_pkg, swr_ram (one per channel window) and swr_mul (shared multiplier).
`default_nettype none

module swr_back
   import swr_pkg::*;
#(
   parameter int WINDOW    = WINDOW_DEF,
   parameter int CODE_BITS = CODE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire q_item_type         q_item,
   output logic                    q_pop,
   input  wire logic [CUT_W-1:0]   cutoff,
   input  wire logic [SIGMA_W-1:0] sigma,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data
);

   localparam int PTR_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int N_W   = $clog2(WINDOW);
   localparam int D_W   = CODE_BITS;
   localparam int SUM_W = D_W + N_W;
   localparam int DEV_W = D_W + N_W + 1;
   localparam int ACC_W = 2 * DEV_W + 14;
   localparam int B_W   = DEV_W;
   localparam int CMP_W = D_W + CUT_W;

   back_state_type state_ff, state_in;

   q_item_type           job_ff;
   logic [CNT_W-1:0]     fill_ff [2];
   logic [PTR_W-1:0]     head_ff [2];
   logic [CODE_BITS-1:0] held_ff [2];
   logic                 seen_ff [2];
   logic [CNT_W-1:0]     idx_ff;
   logic                 pass_ff;
   logic [CODE_BITS-1:0] prev_ff;
   logic [CODE_BITS-1:0] cur_ff;
   logic [D_W-1:0]       dmag_ff;
   logic [SUM_W:0]       sum_ff;
   logic [ACC_W-1:0]     q_ff;
   logic [ACC_W-1:0]     nq_ff;
   logic [ACC_W-1:0]     limit_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 ch;
   logic [CNT_W-1:0]     fill_cur;
   logic [PTR_W-1:0]     head_cur;
   logic                 full;
   logic [CNT_W-1:0]     off;
   logic [CNT_W:0]       asum;
   logic [CNT_W:0]       awrap;
   logic [PTR_W-1:0]     ram_addr;
   logic                 ram_we;
   logic [CODE_BITS-1:0] code;
   logic [CODE_BITS-1:0] rdata0, rdata1, rdata;
   logic signed [D_W:0]  d;
   logic [D_W:0]         dneg;
   logic [D_W-1:0]       dmag;
   logic [N_W-1:0]       n;
   logic [CNT_W-1:0]     n_full;
   logic signed [DEV_W:0] nd;
   logic signed [DEV_W:0] dev;
   logic [DEV_W:0]       devneg;
   logic [DEV_W-1:0]     devmag;
   logic [SUM_W:0]       sumneg;
   logic [SUM_W-1:0]     summag;
   logic [SIGMA_SQ_W-1:0] sm2;
   logic [CNT_W-1:0]     idx_inc;
   logic                 last;
   logic                 mul_start;
   logic [ACC_W-1:0]     mul_a;
   logic [B_W-1:0]       mul_b;
   logic                 mul_done;
   logic [ACC_W-1:0]     mul_prod;
   logic [ACC_W-1:0]     lhs;
   logic                 reject;
   logic                 rsp_load;

   // channel context of the current job
   assign ch       = job_ff.chan1;
   assign fill_cur = fill_ff[ch];
   assign head_cur = head_ff[ch];
   assign full     = (fill_cur == CNT_W'(WINDOW));

   // logical window index to ring address
   assign off      = (state_ff == ST_WRITE) ? (full ? '0 : fill_cur) : idx_ff;
   assign asum     = (CNT_W+1)'(head_cur) + (CNT_W+1)'(off);
   assign awrap    = (asum >= (CNT_W+1)'(WINDOW)) ? asum - (CNT_W+1)'(WINDOW) : asum;
   assign ram_addr = awrap[PTR_W-1:0];

   assign code = CODE_BITS'({{CODE_BITS{1'b0}}, job_ff.code});

   swr_ram #(.WIDTH(CODE_BITS), .DEPTH(WINDOW)) u_win_x (
      .clock (clock),
      .we    (ram_we && !ch),
      .waddr (ram_addr),
      .wdata (code),
      .raddr (ram_addr),
      .rdata (rdata0)
   );

   swr_ram #(.WIDTH(CODE_BITS), .DEPTH(WINDOW)) u_win_z (
      .clock (clock),
      .we    (ram_we && ch),
      .waddr (ram_addr),
      .wdata (code),
      .raddr (ram_addr),
      .rdata (rdata1)
   );

   assign rdata = ch ? rdata1 : rdata0;

   // first difference and its magnitude
   assign d    = $signed({1'b0, rdata}) - $signed({1'b0, prev_ff});
   assign dneg = -d;
   assign dmag = d[D_W] ? dneg[D_W-1:0] : d[D_W-1:0];

   // deviation n*d - sum for the second pass
   assign n_full = fill_cur - CNT_W'(1);
   assign n      = n_full[N_W-1:0];
   assign nd     = $signed({1'b0, n}) * d;
   assign dev    = nd - $signed({sum_ff[SUM_W], sum_ff});
   assign devneg = -dev;
   assign devmag = dev[DEV_W] ? devneg[DEV_W-1:0] : dev[DEV_W-1:0];

   assign sumneg = -sum_ff;
   assign summag = sum_ff[SUM_W] ? sumneg[SUM_W-1:0] : sum_ff[SUM_W-1:0];
   assign sm2    = sigma * sigma;

   assign idx_inc = idx_ff + CNT_W'(1);
   assign last    = (idx_inc == fill_cur);

   // rejection test on the current difference
   assign lhs    = {mul_prod[ACC_W-9:0], 8'b0};
   assign reject = (CMP_W'(dmag_ff) > CMP_W'(cutoff)) && (lhs > limit_ff);

   swr_mul #(.ACC_W(ACC_W), .B_W(B_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and control
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = q_item.keep ? ST_WRITE : ST_RESULT;
            end
         end
         ST_WRITE: begin
            ram_we   = 1'b1;
            state_in = (fill_cur == '0) ? ST_RESULT : ST_READ;
         end
         ST_READ: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (idx_ff == '0) begin
               state_in = ST_READ;
            end else begin
               mul_start = 1'b1;
               if (pass_ff) begin
                  mul_a = ACC_W'(devmag);
                  mul_b = devmag;
               end else begin
                  mul_a = ACC_W'(dmag);
                  mul_b = B_W'(dmag);
               end
               state_in = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            if (mul_done) begin
               if (!last) begin
                  state_in = ST_READ;
               end else if (pass_ff) begin
                  state_in = ST_RESULT;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = q_ff + mul_prod;
                  mul_b     = B_W'(n);
                  state_in  = ST_NQ;
               end
            end
         end
         ST_NQ: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = ACC_W'(summag);
               mul_b     = B_W'(summag);
               state_in  = ST_SQ;
            end
         end
         ST_SQ: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = nq_ff - mul_prod;
               mul_b     = B_W'(sm2);
               state_in  = ST_LIM;
            end
         end
         ST_LIM: begin
            if (mul_done) begin
               state_in = ST_READ;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // window bookkeeping, held codes and output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         head_ff[0]   <= '0;
         head_ff[1]   <= '0;
         held_ff[0]   <= '0;
         held_ff[1]   <= '0;
         seen_ff[0]   <= 1'b0;
         seen_ff[1]   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_WRITE) begin
            if (full) begin
               head_ff[ch] <= (head_cur == PTR_W'(WINDOW - 1)) ? '0 : head_cur + PTR_W'(1);
            end else begin
               fill_ff[ch] <= fill_cur + CNT_W'(1);
            end
         end
         if ((state_ff == ST_MWAIT) && mul_done && pass_ff && !reject) begin
            held_ff[ch] <= cur_ff;
            seen_ff[ch] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pass datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_item;
      end
      case (state_ff)
         ST_WRITE: begin
            idx_ff  <= '0;
            pass_ff <= 1'b0;
            sum_ff  <= '0;
            q_ff    <= '0;
         end
         ST_DATA: begin
            prev_ff <= rdata;
            if (idx_ff == '0) begin
               idx_ff <= CNT_W'(1);
            end else begin
               cur_ff  <= rdata;
               dmag_ff <= dmag;
               if (!pass_ff) begin
                  sum_ff <= sum_ff + {{N_W{d[D_W]}}, d};
               end
            end
         end
         ST_MWAIT: begin
            if (mul_done) begin
               idx_ff <= idx_inc;
               if (!pass_ff) begin
                  q_ff <= q_ff + mul_prod;
               end
            end
         end
         ST_NQ: begin
            if (mul_done) begin
               nq_ff <= mul_prod;
            end
         end
         ST_LIM: begin
            if (mul_done) begin
               limit_ff <= mul_prod;
               pass_ff  <= 1'b1;
               idx_ff   <= '0;
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_data_ff.x_code  <= OUT_CODE_W'({{OUT_CODE_W{1'b0}}, held_ff[0]});
         rsp_data_ff.x_valid <= seen_ff[0];
         rsp_data_ff.z_code  <= OUT_CODE_W'({{OUT_CODE_W{1'b0}}, held_ff[1]});
         rsp_data_ff.z_valid <= seen_ff[1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/two_channel_window_outlier_reject_top.sv
// Top level of the two-channel sliding-window outlier reject block.
// Depends on swr_pkg, swr_front and swr_back (which uses swr_ram and swr_mul).
//
//  channel  dir   handshake              payload
//  req      in    req_valid / req_ready  req_data   (sample_code, chan)
//  rsp      out   rsp_valid / rsp_ready  rsp_data   (x_code, x_valid, z_code, z_valid)
//  csr      in    csr_we                 csr_addr, csr_wdata
//
// A beat on channel 2 or 3 goes straight from the queue to the response register without
// touching the windows, and a stored beat that leaves fewer than two window entries skips the
// passes. With n >= 1 differences the work is paced by the shared multiplier, which retires
// 8 bits of its second operand per cycle; a stalled rsp holds the back end until it is taken.
// Reset is synchronous and clears windows' fill counts, held codes and registers.
// A two-beat queue lets requests land while the back end works or rsp stalls.
`default_nettype none

module two_channel_window_outlier_reject_top
   import swr_pkg::*;
#(
   parameter int WINDOW    = WINDOW_DEF,
   parameter int CODE_BITS = CODE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CUT_W-1:0]   cutoff_ff;
   logic [SIGMA_W-1:0] sigma_ff;
   logic               q_valid;
   logic               q_pop;
   q_item_type         q_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RST;
         sigma_ff  <= SIGMA_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CUTOFF: cutoff_ff <= csr_wdata[CUT_W-1:0];
            CSR_SIGMA:  sigma_ff  <= csr_wdata[SIGMA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   swr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   swr_back #(.WINDOW(WINDOW), .CODE_BITS(CODE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .cutoff    (cutoff_ff),
      .sigma     (sigma_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // back end only pops a queued beat
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // an accepted request is queued on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_valid)
      else $error("accepted beat missing from queue");
`endif

endmodule

`default_nettype wire

>>> verif/two_channel_window_outlier_reject_top_tb.sv
// Testbench for two_channel_window_outlier_reject_top: directed table, then random beats,
// checked against an in-bench window/outlier predictor. Depends on swr_pkg and the rtl.
`timescale 1ns / 100ps

module two_channel_window_outlier_reject_top_tb
   import swr_pkg::*;
();

   localparam int WIN            = WINDOW_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DIR_ROWS       = 16;
   localparam int PHASE_ITEMS    = 158;

   // channel tags that are ignored, and a register index beyond the list
   localparam logic [CHAN_W-1:0]     CHAN_AUX_LO = 2'd2;
   localparam logic [CHAN_W-1:0]     CHAN_AUX_HI = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED  = 2'd2;

   logic clock, reset;
   logic req_valid, req_ready;
   req_type req_data;
   logic rsp_valid, rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   two_channel_window_outlier_reject_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // directed or random stimulus row; fixed holds the response known up front
   typedef struct packed {
      req_type beat;
      logic    has_fixed;
      rsp_type fixed;
   } dir_row_type;

   typedef struct packed {
      rsp_type want;
      logic    has_fixed;
      rsp_type fixed;
   } expect_type;

   // predictor state
   logic [23:0] cut_reg;
   logic [7:0]  sig_reg;
   logic [23:0] win_q [2][WIN];
   int          fill_q [2];
   logic [23:0] held_q [2];
   logic        seen_q [2];

   dir_row_type dir_table [DIR_ROWS];
   dir_row_type stim_q [$];
   dir_row_type cur_row;
   expect_type  expect_q [$];
   logic [23:0] base_code [2];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   function automatic logic [127:0] mag_of(logic signed [63:0] v);
      return v < 0 ? 128'(-v) : 128'(v);
   endfunction

   task automatic predictor_reset();
      cut_reg = CUTOFF_RST;
      sig_reg = SIGMA_RST;
      for (int c = 0; c < 2; c++) begin
         fill_q[c] = 0;
         held_q[c] = '0;
         seen_q[c] = 1'b0;
         for (int i = 0; i < WIN; i++) win_q[c][i] = '0;
      end
   endtask

   // run the reject test over one channel's window
   task automatic judge_window(int c);
      int n;
      logic signed [63:0] d, total, dev;
      logic [127:0] sq, spread, limit, lhs;
      if (fill_q[c] < 2) return;
      n = fill_q[c] - 1;
      total = 0;
      sq = 0;
      for (int i = 1; i < fill_q[c]; i++) begin
         d = $signed({40'd0, win_q[c][i]}) - $signed({40'd0, win_q[c][i-1]});
         total += d;
         sq += mag_of(d) * mag_of(d);
      end
      spread = sq * n - mag_of(total) * mag_of(total);
      limit = spread * (sig_reg * sig_reg);
      for (int i = 1; i < fill_q[c]; i++) begin
         d = $signed({40'd0, win_q[c][i]}) - $signed({40'd0, win_q[c][i-1]});
         dev = n * d - total;
         lhs = mag_of(dev) * mag_of(dev) * 256;
         if (!(mag_of(d) > cut_reg && lhs > limit)) begin
            held_q[c] = win_q[c][i];
            seen_q[c] = 1'b1;
         end
      end
   endtask

   function automatic rsp_type held_now();
      rsp_type r;
      r.x_code = held_q[0]; r.x_valid = seen_q[0];
      r.z_code = held_q[1]; r.z_valid = seen_q[1];
      return r;
   endfunction

   task automatic predict_beat(req_type b);
      int c;
      if (b.chan == CHAN_X || b.chan == CHAN_Z) begin
         c = (b.chan == CHAN_Z) ? 1 : 0;
         if (fill_q[c] >= WIN) begin
            for (int i = 0; i < WIN - 1; i++) win_q[c][i] = win_q[c][i+1];
            fill_q[c] = WIN - 1;
         end
         win_q[c][fill_q[c]] = b.sample_code;
         fill_q[c]++;
         judge_window(c);
      end
   endtask

   function automatic rsp_type make_rsp(logic [23:0] xc, logic xv, logic [23:0] zc, logic zv);
      rsp_type r;
      r.x_code = xc; r.x_valid = xv;
      r.z_code = zc; r.z_valid = zv;
      return r;
   endfunction

   function automatic dir_row_type make_row(logic [23:0] code, logic [1:0] chan,
                                            logic has_fixed, rsp_type fixed);
      dir_row_type r;
      r.beat.sample_code = code;
      r.beat.chan        = chan;
      r.has_fixed        = has_fixed;
      r.fixed            = fixed;
      return r;
   endfunction

   // directed rows: ignored tags, short windows, small steps, a rejected spike, extremes
   task automatic build_table();
      rsp_type none;
      none = '0;
      dir_table[0]  = make_row(24'h123456, CHAN_AUX_LO, 1'b1, none);
      dir_table[1]  = make_row(24'hFFFFFF, CHAN_AUX_HI, 1'b1, none);
      dir_table[2]  = make_row(24'd1000, CHAN_X, 1'b1, none);
      dir_table[3]  = make_row(24'hFFFFFF, CHAN_Z, 1'b1, none);
      dir_table[4]  = make_row(24'd1010, CHAN_X, 1'b1,
                               make_rsp(24'd1010, 1'b1, 24'd0, 1'b0));
      dir_table[5]  = make_row(24'hFFFFF0, CHAN_Z, 1'b1,
                               make_rsp(24'd1010, 1'b1, 24'hFFFFF0, 1'b1));
      dir_table[6]  = make_row(24'd1020, CHAN_X, 1'b1,
                               make_rsp(24'd1020, 1'b1, 24'hFFFFF0, 1'b1));
      dir_table[7]  = make_row(24'd0, CHAN_AUX_LO, 1'b1,
                               make_rsp(24'd1020, 1'b1, 24'hFFFFF0, 1'b1));
      dir_table[8]  = make_row(24'hFFFFFF, CHAN_X, 1'b1,
                               make_rsp(24'd1020, 1'b1, 24'hFFFFF0, 1'b1));
      dir_table[9]  = make_row(24'd1030, CHAN_X, 1'b0, none);
      dir_table[10] = make_row(24'd0, CHAN_Z, 1'b0, none);
      dir_table[11] = make_row(24'hFFFFFF, CHAN_Z, 1'b0, none);
      dir_table[12] = make_row(24'd0, CHAN_X, 1'b0, none);
      dir_table[13] = make_row(24'h800000, CHAN_Z, 1'b0, none);
      dir_table[14] = make_row(24'd1040, CHAN_X, 1'b0, none);
      dir_table[15] = make_row(24'hFFFFF8, CHAN_AUX_HI, 1'b0, none);
   endtask

   // noisy codes around a per-channel baseline, with spikes and baseline jumps
   function automatic dir_row_type random_row();
      int          pick;
      int          c;
      logic [23:0] code;
      logic [1:0]  chan;
      pick = int'($urandom_range(99));
      if (pick < 45) chan = CHAN_X;
      else if (pick < 90) chan = CHAN_Z;
      else if (pick < 95) chan = CHAN_AUX_LO;
      else chan = CHAN_AUX_HI;
      c = (chan == CHAN_Z) ? 1 : 0;
      pick = int'($urandom_range(99));
      if (pick < 2) base_code[c] = 24'($urandom);
      if (pick >= 2 && pick < 8) code = 24'($urandom);
      else code = base_code[c] + 24'($urandom_range(400)) - 24'd200;
      return make_row(code, chan, 1'b0, '0);
   endfunction

   // drive, check and watch every beat
   always @(posedge clock) begin : bench
      expect_type e;
      if (reset) begin
         req_valid    <= 1'b0;
         req_data     <= '0;
         rsp_ready    <= 1'b0;
         quiet_cycles = 0;
         predictor_reset();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_CUTOFF: cut_reg = csr_wdata[CUT_W-1:0];
               CSR_SIGMA:  sig_reg = csr_wdata[SIGMA_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expect_q.size() == 0) begin
               report_mismatch("unexpected rsp", 64'(rsp_data), 64'd0);
            end else begin
               e = expect_q.pop_front();
               if (rsp_data != e.want) begin
                  report_mismatch("rsp vs predictor", 64'(rsp_data), 64'(e.want));
               end
               if (e.has_fixed && rsp_data != e.fixed) begin
                  report_mismatch("rsp vs table", 64'(rsp_data), 64'(e.fixed));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_beat(req_data);
            e.want      = held_now();
            e.has_fixed = cur_row.has_fixed;
            e.fixed     = cur_row.fixed;
            expect_q.push_back(e);
         end
         // watchdog on cycles without any accepted beat or register write
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("two_channel_window_outlier_reject_top_tb: FAIL");
            $finish;
         end
         // next request beat
         if (!req_valid || req_ready) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_row = stim_q.pop_front();
               req_valid <= 1'b1;
               req_data  <= cur_row.beat;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (stim_q.size() != 0 || req_valid || expect_q.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) stim_q.push_back(random_row());
      drain();
   endtask

   initial begin : main
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;
      base_code[0] = 24'h400000;
      base_code[1] = 24'h9A0000;
      build_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) stim_q.push_back(dir_table[i]);
      drain();

      // random phases with configuration changes between them
      run_phase(0, 0);
      write_csr(CSR_CUTOFF, 24'd2000);
      write_csr(CSR_SIGMA, 24'd40);
      run_phase(84, 0);
      write_csr(CSR_SIGMA, 24'd0);
      write_csr(CSR_CUTOFF, 24'd0);
      write_csr(CSR_UNUSED, 24'hFFFFFF);
      run_phase(0, 84);
      write_csr(CSR_CUTOFF, 24'd150);
      write_csr(CSR_SIGMA, 24'd255);
      run_phase(8, 8);

      if (fail_count == 0) begin
         $display("two_channel_window_outlier_reject_top_tb: PASS");
      end else begin
         $display("two_channel_window_outlier_reject_top_tb: FAIL");
      end
      $finish;
   end

endmodule
